### sv/u8cp_pkg.sv
// Shared types and constants for the UTF-8 to code point decoder.
package u8cp_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int CP_BITS     = 21;
    localparam int BYTE_BITS   = 8;
    localparam int TDATA_OUT_BITS = ((CP_BITS + OFFSET_BITS + 7) / 8) * 8;
    localparam int TDATA_PAD_BITS = TDATA_OUT_BITS - CP_BITS - OFFSET_BITS;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [CP_BITS-1:0]     REPL_RESET = CP_BITS'(8'h3F);
    localparam logic [CP_BITS-1:0]     MIN_2BYTE  = CP_BITS'(32'h0000_0080);
    localparam logic [CP_BITS-1:0]     MIN_3BYTE  = CP_BITS'(32'h0000_0800);
    localparam logic [CP_BITS-1:0]     MIN_4BYTE  = CP_BITS'(32'h0001_0000);

    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

    typedef struct packed {
        logic [1:0]             rem;
        logic [2:0]             len;
        logic [CP_BITS-1:0]     acc;
        logic [OFFSET_BITS-1:0] lead;
        logic [OFFSET_BITS-1:0] cnt;
        logic                   disc;
    } t_state;

    // Up to four results of one input byte, offsets counted up from base.
    typedef struct packed {
        logic [2:0]             num;
        logic [CP_BITS-1:0]     cp;
        logic [OFFSET_BITS-1:0] base;
        logic                   err;
        logic                   eos;
    } t_result;

    function automatic logic [OFFSET_BITS-1:0] sat_add(
        input logic [OFFSET_BITS-1:0] a,
        input logic [1:0]             b
    );
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + {{(OFFSET_BITS-1){1'b0}}, b};
        return s[OFFSET_BITS] ? OFFSET_MAX : s[OFFSET_BITS-1:0];
    endfunction

endpackage

### sv/u8cp_decode.sv
// Combinational next-state and result logic for one input byte.
module u8cp_decode import u8cp_pkg::*; (
    input  t_state                i_st,
    input  logic [BYTE_BITS-1:0]  i_byte,
    input  logic                  i_last,
    input  logic [CP_BITS-1:0]    i_repl,
    output t_state                o_next,
    output t_result               o_res
);

    logic [1:0]         rem_dec;
    logic [CP_BITS-1:0] acc_new;
    logic [CP_BITS-1:0] cont_bits;
    logic [CP_BITS-1:0] minimum;

    assign rem_dec   = i_st.rem - 2'd1;
    assign cont_bits = CP_BITS'(i_byte[5:0]);

    always_comb begin
        case (rem_dec)
            2'd0:    acc_new = i_st.acc | cont_bits;
            2'd1:    acc_new = i_st.acc | (cont_bits << 6);
            default: acc_new = i_st.acc | (cont_bits << 12);
        endcase
    end

    always_comb begin
        case (i_st.len)
            LEN_2:   minimum = MIN_2BYTE;
            LEN_3:   minimum = MIN_3BYTE;
            default: minimum = MIN_4BYTE;
        endcase
    end

    always_comb begin
        o_next    = i_st;
        o_res.num = 3'd0;
        o_res.cp  = '0;
        o_res.base = i_st.cnt;
        o_res.err = 1'b0;
        o_res.eos = i_last;

        if (i_st.disc) begin
            if (i_last) begin
                o_res.num = 3'd1;
                o_res.err = 1'b1;
            end
        end else if (i_st.rem == 2'd0) begin
            if (!i_byte[7]) begin
                o_res.num = 3'd1;
                o_res.cp  = CP_BITS'(i_byte);
            end else if (i_byte[7:6] == 2'b11 && i_byte[5:3] != 3'b111) begin
                // open a sequence at this lead byte
                o_next.lead = i_st.cnt;
                case (i_byte[5:4])
                    2'b00, 2'b01: begin
                        o_next.acc = CP_BITS'(i_byte[4:0]) << 6;
                        o_next.rem = 2'd1;
                        o_next.len = LEN_2;
                    end
                    2'b10: begin
                        o_next.acc = CP_BITS'(i_byte[3:0]) << 12;
                        o_next.rem = 2'd2;
                        o_next.len = LEN_3;
                    end
                    default: begin
                        o_next.acc = CP_BITS'(i_byte[2:0]) << 18;
                        o_next.rem = 2'd3;
                        o_next.len = LEN_4;
                    end
                endcase
                if (i_last) begin
                    o_res.num = 3'd1;
                    o_res.err = 1'b1;
                end
            end else begin
                o_res.num = 3'd1;
                o_res.cp  = i_repl;
            end
        end else if (i_byte[7:6] == 2'b10) begin
            o_next.rem = rem_dec;
            o_next.acc = acc_new;
            if (rem_dec == 2'd0) begin
                o_res.base = i_st.lead;
                if (acc_new >= minimum) begin
                    o_res.num = 3'd1;
                    o_res.cp  = acc_new;
                end else begin
                    // overlong: one replacement per byte of the sequence
                    o_res.num = i_st.len;
                    o_res.cp  = i_repl;
                end
                o_next.rem  = 2'd0;
                o_next.len  = 3'd0;
                o_next.acc  = '0;
                o_next.lead = '0;
            end else if (i_last) begin
                o_res.num = 3'd1;
                o_res.err = 1'b1;
            end
        end else begin
            o_res.num   = 3'd1;
            o_res.err   = 1'b1;
            o_next.disc = 1'b1;
        end

        if (i_last) begin
            o_next.rem  = 2'd0;
            o_next.len  = 3'd0;
            o_next.acc  = '0;
            o_next.lead = '0;
            o_next.cnt  = '0;
            o_next.disc = 1'b0;
        end else begin
            o_next.cnt = sat_add(i_st.cnt, 2'd1);
        end
    end

endmodule

### sv/utf8_to_code_point_decoder_unit.sv
// UTF-8 decoder top level: byte stream in, code points with offsets out.
//
//  channel | direction | tdata                          | tlast        | tuser
//  s       | in        | data_byte                      | last_in_str. | -
//  m       | out       | codepoint, byte_offset         | last_of_run  | decode_error, eos
//  cfg     | in        | replacement_char (write only)  | -            | -
//
// One byte is accepted per cycle while the result register is empty or drains;
// its results show on the next cycle. A byte that closes an overlong sequence
// gives 2 to 4 results, one per cycle while m is ready, and the input waits until the result register drains.
// Reset clears the decode state and empties the result register; the
// replacement character returns to a question mark. A stall on m holds
// the input off only when the pending results are not taken this cycle.
module utf8_to_code_point_decoder_unit import u8cp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [BYTE_BITS-1:0]      i_s_tdata,   // [7:0] data_byte
    input  logic                      i_s_tlast,   // last_in_string
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [TDATA_OUT_BITS-1:0] o_m_tdata,   // [20:0] codepoint, [36:21] byte_offset
    output logic [1:0]                o_m_tuser,   // [0] decode_error, [1] end_of_string
    output logic                      o_m_tlast,   // last_of_run
    input  logic                      i_cfg_we,
    input  logic [CP_BITS-1:0]        i_cfg_wdata  // replacement_char
);

    logic [CP_BITS-1:0]     r_repl;
    t_state                 r_st;
    t_state                 n_st;
    t_result                dec_res;

    logic                   r_valid;
    logic [1:0]             r_idx;
    logic [1:0]             r_last_idx;
    logic [CP_BITS-1:0]     r_cp;
    logic [OFFSET_BITS-1:0] r_base;
    logic                   r_err;
    logic                   r_eos;

    logic pop;
    logic drain_done;
    logic accept;

    u8cp_decode u_decode (
        .i_st   (r_st),
        .i_byte (i_s_tdata),
        .i_last (i_s_tlast),
        .i_repl (r_repl),
        .o_next (n_st),
        .o_res  (dec_res)
    );

    assign pop        = r_valid && i_m_tready;
    assign drain_done = pop && (r_idx == r_last_idx);
    assign o_s_tready = !r_valid || drain_done;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= REPL_RESET;
        end else if (i_cfg_we) begin
            r_repl <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_idx      <= 2'd0;
            r_last_idx <= 2'd0;
        end else if (accept && dec_res.num != 3'd0) begin
            r_valid    <= 1'b1;
            r_idx      <= 2'd0;
            r_last_idx <= 2'(dec_res.num - 3'd1);
        end else if (drain_done) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // load the payload with each new beat group
    always_ff @(posedge i_clk) begin
        if (accept && dec_res.num != 3'd0) begin
            r_cp   <= dec_res.cp;
            r_base <= dec_res.base;
            r_err  <= dec_res.err;
            r_eos  <= dec_res.eos;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{TDATA_PAD_BITS{1'b0}}, sat_add(r_base, r_idx), r_cp};
    assign o_m_tuser  = {r_eos, r_err};
    assign o_m_tlast  = (r_idx == r_last_idx);

endmodule

### test/testbench.sv
// Self-checking bench for the UTF-8 decoder: stream stimulus, scoreboard, byte-level predictor.
module testbench;
    import u8cp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int          SETTLE_CYCLES = 8;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] CONT_MIN    = 8'h80;
    localparam logic [7:0] CONT_MAX    = 8'hBF;
    localparam logic [7:0] LEAD2_MIN   = 8'hC0;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD4_MAX   = 8'hF7;
    localparam logic [7:0] INVALID_MIN = 8'hF8;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        logic [CP_BITS-1:0]     cp;
        logic [OFFSET_BITS-1:0] off;
        logic                   err;
        logic                   run_last;
        logic                   eos;
    } t_point;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    logic [BYTE_BITS-1:0]      i_s_tdata = '0;      // [7:0] data_byte
    logic                      i_s_tlast = 1'b0;    // last_in_string
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    logic [TDATA_OUT_BITS-1:0] o_m_tdata;           // [20:0] codepoint, [36:21] byte_offset
    logic [1:0]                o_m_tuser;           // [0] decode_error, [1] end_of_string
    logic                      o_m_tlast;           // last_of_run
    logic                      i_cfg_we = 1'b0;
    logic [CP_BITS-1:0]        i_cfg_wdata = '0;    // replacement_char

    utf8_to_code_point_decoder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Decoder shadow state
    logic [CP_BITS-1:0]     repl_char = REPL_RESET;
    logic [1:0]             need_cont = '0;
    logic [2:0]             seq_len = '0;
    logic [CP_BITS-1:0]     acc_cp = '0;
    logic [OFFSET_BITS-1:0] lead_off = '0;
    logic [OFFSET_BITS-1:0] byte_pos = '0;
    logic                   discarding = 1'b0;

    t_point      pending_points[$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    bit          tx_gaps = 1'b0;
    bit          rx_stalls = 1'b0;
    int          hold_request = 0;
    int          stall_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] offset_plus(
        input logic [OFFSET_BITS-1:0] base,
        input int                     k
    );
        logic [OFFSET_BITS:0] sum;
        sum = {1'b0, base} + (OFFSET_BITS+1)'(k);
        return sum[OFFSET_BITS] ? OFFSET_MAX : sum[OFFSET_BITS-1:0];
    endfunction

    function automatic t_point make_point(
        input logic [CP_BITS-1:0]     cp,
        input logic [OFFSET_BITS-1:0] off,
        input logic                   err,
        input logic                   eos
    );
        t_point p;
        p.cp       = cp;
        p.off      = off;
        p.err      = err;
        p.run_last = 1'b0;
        p.eos      = eos;
        return p;
    endfunction

    // Advance the shadow decoder by one accepted byte and queue what it yields.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        t_point                 batch[$];
        logic [OFFSET_BITS-1:0] off;
        logic [CP_BITS-1:0]     floor_cp;
        int                     k;
        off = byte_pos;
        if (discarding) begin
            if (last) batch.insert(batch.size(), make_point('0, off, 1'b1, 1'b1));
        end else if (need_cont == 2'd0) begin
            if (b <= ASCII_MAX) begin
                batch.insert(batch.size(), make_point(CP_BITS'(b), off, 1'b0, last));
            end else if (b >= LEAD2_MIN && b <= LEAD4_MAX) begin
                lead_off = off;
                if (b <= LEAD2_MAX) begin
                    acc_cp    = CP_BITS'(b[4:0]) << 6;
                    need_cont = 2'd1;
                    seq_len   = LEN_2;
                end else if (b <= LEAD3_MAX) begin
                    acc_cp    = CP_BITS'(b[3:0]) << 12;
                    need_cont = 2'd2;
                    seq_len   = LEN_3;
                end else begin
                    acc_cp    = CP_BITS'(b[2:0]) << 18;
                    need_cont = 2'd3;
                    seq_len   = LEN_4;
                end
                if (last) batch.insert(batch.size(), make_point('0, off, 1'b1, 1'b1));
            end else begin
                batch.insert(batch.size(), make_point(repl_char, off, 1'b0, last));
            end
        end else if (b >= CONT_MIN && b <= CONT_MAX) begin
            need_cont = need_cont - 2'd1;
            acc_cp    = acc_cp | (CP_BITS'(b[5:0]) << (6 * need_cont));
            if (need_cont == 2'd0) begin
                floor_cp = (seq_len == LEN_2) ? MIN_2BYTE :
                           (seq_len == LEN_3) ? MIN_3BYTE : MIN_4BYTE;
                if (acc_cp >= floor_cp) begin
                    batch.insert(batch.size(), make_point(acc_cp, lead_off, 1'b0, last));
                end else begin
                    // overlong: one replacement per byte of the sequence
                    for (k = 0; k < int'(seq_len); k++)
                        batch.insert(batch.size(),
                                     make_point(repl_char, offset_plus(lead_off, k),
                                                1'b0, last));
                end
                seq_len  = '0;
                acc_cp   = '0;
                lead_off = '0;
            end else if (last) begin
                batch.insert(batch.size(), make_point('0, off, 1'b1, 1'b1));
            end
        end else begin
            batch.insert(batch.size(), make_point('0, off, 1'b1, last));
            discarding = 1'b1;
        end

        if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
        foreach (batch[i]) pending_points.insert(pending_points.size(), batch[i]);

        if (last) begin
            need_cont  = '0;
            seq_len    = '0;
            acc_cp     = '0;
            lead_off   = '0;
            byte_pos   = '0;
            discarding = 1'b0;
        end else begin
            byte_pos = offset_plus(byte_pos, 1);
        end
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls plus an on-demand long hold-off.
    always @(posedge i_clk) begin
        if (stall_left == 0 && hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end else if (stall_left == 0 && rx_stalls && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_points
        t_point want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected beat: codepoint %h offset %h", o_m_tdata[CP_BITS-1:0],
                       o_m_tdata[CP_BITS +: OFFSET_BITS]);
                mismatches++;
            end else begin
                want = pending_points.pop_front();
                if (o_m_tdata[CP_BITS-1:0] !== want.cp) begin
                    $error("codepoint: expected %h, got %h", want.cp,
                           o_m_tdata[CP_BITS-1:0]);
                    mismatches++;
                end
                if (o_m_tdata[CP_BITS +: OFFSET_BITS] !== want.off) begin
                    $error("byte_offset: expected %h, got %h", want.off,
                           o_m_tdata[CP_BITS +: OFFSET_BITS]);
                    mismatches++;
                end
                if (o_m_tuser[0] !== want.err) begin
                    $error("decode_error: expected %b, got %b", want.err, o_m_tuser[0]);
                    mismatches++;
                end
                if (o_m_tlast !== want.run_last) begin
                    $error("last_of_run: expected %b, got %b", want.run_last, o_m_tlast);
                    mismatches++;
                end
                if (o_m_tuser[1] !== want.eos) begin
                    $error("end_of_string: expected %b, got %b", want.eos, o_m_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        decode_byte(b, last);
    endtask

    task automatic send_string(input t_byte_q s);
        foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    endtask

    // Drop valid, let every expected beat arrive, then let the pipe settle.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_replacement(input logic [CP_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        repl_char = value;
    endtask

    task automatic encode_point(ref t_byte_q s, input logic [CP_BITS-1:0] cp, input int len);
        case (len)
            1: s.insert(s.size(), cp[7:0]);
            2: begin
                s.insert(s.size(), {3'b110, cp[10:6]});
                s.insert(s.size(), {2'b10, cp[5:0]});
            end
            3: begin
                s.insert(s.size(), {4'b1110, cp[15:12]});
                s.insert(s.size(), {2'b10, cp[11:6]});
                s.insert(s.size(), {2'b10, cp[5:0]});
            end
            default: begin
                s.insert(s.size(), {5'b11110, cp[20:18]});
                s.insert(s.size(), {2'b10, cp[17:12]});
                s.insert(s.size(), {2'b10, cp[11:6]});
                s.insert(s.size(), {2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_char(ref t_byte_q s);
        int         pick;
        int         len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            encode_point(s, CP_BITS'($urandom_range(0, 'h7F)), 1);
        end else if (pick < 46) begin
            encode_point(s, CP_BITS'($urandom_range('h80, 'h7FF)), 2);
        end else if (pick < 60) begin
            encode_point(s, CP_BITS'($urandom_range('h800, 'hFFFF)), 3);
        end else if (pick < 72) begin
            encode_point(s, CP_BITS'($urandom_range('h10000, 'h1FFFFF)), 4);
        end else if (pick < 82) begin
            len = $urandom_range(2, 4);
            encode_point(s, CP_BITS'($urandom_range(0, len == 2 ? 'h7F :
                                                       len == 3 ? 'h7FF : 'hFFFF)), len);
        end else if (pick < 90) begin
            if ($urandom_range(0, 1) == 1)
                s.insert(s.size(), 8'($urandom_range(CONT_MIN, CONT_MAX)));
            else s.insert(s.size(), 8'($urandom_range(INVALID_MIN, 'hFF)));
        end else if (pick < 94) begin
            s.insert(s.size(), 8'($urandom_range(0, 'hFF)));
        end else begin
            // lead byte, maybe a continuation, then a byte that is not a continuation
            s.insert(s.size(), 8'($urandom_range(LEAD2_MIN, LEAD4_MAX)));
            if ($urandom_range(0, 1) == 1)
                s.insert(s.size(), 8'($urandom_range(CONT_MIN, CONT_MAX)));
            b = 8'($urandom_range(0, 'hFF));
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            s.insert(s.size(), b);
        end
    endtask

    task automatic test_valid_sequences();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        send_string('{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC});
        // largest 4-byte value and a surrogate, both accepted
        send_string('{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80});
    endtask

    task automatic test_overlong_and_invalid();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_string('{8'hF0, 8'h80, 8'h80, 8'h80});
        send_string('{8'h80, 8'hF8, 8'hFF});
        // bad continuation, then bytes dropped up to the string end
        send_string('{8'hC3, 8'h41, 8'h42});
        send_string('{8'hE2, 8'h82});
        send_string('{8'hF0});
    endtask

    task automatic test_replacement_setting();
        logic [CP_BITS-1:0] settings[4];
        settings = '{'0, {CP_BITS{1'b1}}, CP_BITS'($urandom_range(0, 'h1FFFFF)), REPL_RESET};
        foreach (settings[i]) begin
            wait_idle();
            write_replacement(settings[i]);
            send_string('{8'h41, 8'h80, 8'hFF, 8'hC1, 8'hBF, 8'hE0, 8'h9F, 8'hBF});
        end
    endtask

    task automatic test_receiver_holdoff();
        t_byte_q s;
        wait_idle();
        tx_gaps      = 1'b0;
        rx_stalls    = 1'b0;
        hold_request = 150;
        repeat (10) add_char(s);
        send_string(s);
        wait_idle();
    endtask

    task automatic test_random_strings();
        t_byte_q s;
        int      sent;
        sent = 0;
        while (sent < 50) begin
            if ($urandom_range(0, 5) == 0) begin
                tx_gaps   = 1'($urandom_range(0, 1));
                rx_stalls = 1'($urandom_range(0, 1));
            end
            s.delete();
            repeat ($urandom_range(1, 6)) add_char(s);
            // occasionally drop the last byte, which may end the string inside a sequence
            if (s.size() > 1 && $urandom_range(0, 9) == 0) void'(s.pop_back());
            send_string(s);
            sent += s.size();
            if ($urandom_range(0, 15) == 0) wait_idle();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_valid_sequences();
        test_overlong_and_invalid();
        test_replacement_setting();
        test_receiver_holdoff();
        test_random_strings();
        wait_idle();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### utf8_to_code_point_decoder_unit.f
sv/u8cp_pkg.sv
sv/u8cp_decode.sv
sv/utf8_to_code_point_decoder_unit.sv
test/testbench.sv
